FILE: rtl/core/hpdq_pkg.sv
// Shared types and constants for the hot-plug-detect event queue.
// Holds event codes, register indexes, reset values and inter-module structs.
// Depends on nothing.
package hpdq_pkg;

    localparam int QUEUE_SLOTS_DEF = 4;
    localparam int TIMER_BITS_DEF  = 25;
    localparam int CFG_W           = 24;

    localparam logic [1:0] EV_NONE = 2'd0;
    localparam logic [1:0] EV_LOW  = 2'd1;
    localparam logic [1:0] EV_HIGH = 2'd2;
    localparam logic [1:0] EV_IRQ  = 2'd3;

    localparam logic [1:0] CFG_GLITCH_LIMIT = 2'd0;
    localparam logic [1:0] CFG_IRQ_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_LEVEL_DELAY  = 2'd2;
    localparam logic [1:0] CFG_QUEUE_GAP    = 2'd3;

    localparam logic [CFG_W-1:0] GLITCH_LIMIT_RST = 24'd150;
    localparam logic [CFG_W-1:0] IRQ_LIMIT_RST    = 24'd2000;
    localparam logic [CFG_W-1:0] LEVEL_DELAY_RST  = 24'd100000;
    localparam logic [CFG_W-1:0] QUEUE_GAP_RST    = 24'd4000;

    localparam int OFIFO_AW    = 3;
    localparam int OFIFO_DEPTH = 1 << OFIFO_AW;

    typedef struct packed {
        logic [CFG_W-1:0] glitch_limit;
        logic [CFG_W-1:0] irq_limit;
        logic [CFG_W-1:0] level_delay;
        logic [CFG_W-1:0] queue_gap;
    } t_cfg;

    typedef struct packed {
        logic [1:0] num;
        logic [1:0] code0;
        logic [1:0] code1;
    } t_push;

    typedef struct packed {
        logic       last;
        logic [1:0] code;
    } t_ofifo_ent;

endpackage

FILE: rtl/core/hpdq_cfg_regs.sv
// Configuration register file for the hot-plug-detect event queue.
// Depends on hpdq_pkg for register indexes, reset values and t_cfg.
module hpdq_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_index,
    input  logic [hpdq_pkg::CFG_W-1:0]    i_data,
    output hpdq_pkg::t_cfg                o_cfg
);
    import hpdq_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_ready = i_rst_n;
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            case (i_index)
                CFG_GLITCH_LIMIT: n_cfg.glitch_limit = i_data;
                CFG_IRQ_LIMIT:    n_cfg.irq_limit    = i_data;
                CFG_LEVEL_DELAY:  n_cfg.level_delay  = i_data;
                CFG_QUEUE_GAP:    n_cfg.queue_gap    = i_data;
                default:          n_cfg              = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.glitch_limit <= GLITCH_LIMIT_RST;
            r_cfg.irq_limit    <= IRQ_LIMIT_RST;
            r_cfg.level_delay  <= LEVEL_DELAY_RST;
            r_cfg.queue_gap    <= QUEUE_GAP_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: rtl/core/hpdq_out_fifo.sv
// Result FIFO that takes up to two events per cycle and sends one per transfer.
// Depends on hpdq_pkg for t_push, t_ofifo_ent and the FIFO depth.
module hpdq_out_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hpdq_pkg::t_push               i_push,
    output logic [hpdq_pkg::OFIFO_AW:0]   o_count,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_code,
    output logic                          o_last
);
    import hpdq_pkg::*;

    t_ofifo_ent            r_mem [OFIFO_DEPTH];
    logic [OFIFO_AW-1:0]   r_wr;
    logic [OFIFO_AW-1:0]   r_rd;
    logic [OFIFO_AW:0]     r_cnt;
    logic                  pop;
    logic [OFIFO_AW-1:0]   wr_nxt;

    assign o_valid = (r_cnt != '0);
    assign o_code  = r_mem[r_rd].code;
    assign o_last  = r_mem[r_rd].last;
    assign o_count = r_cnt;
    assign pop     = o_valid && i_ready;
    assign wr_nxt  = r_wr + OFIFO_AW'(1);

    always_ff @(posedge i_clk) begin
        if (i_push.num != 2'd0) begin
            r_mem[r_wr].code <= i_push.code0;
            r_mem[r_wr].last <= (i_push.num == 2'd1);
        end
        if (i_push.num == 2'd2) begin
            r_mem[wr_nxt].code <= i_push.code1;
            r_mem[wr_nxt].last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= r_wr + OFIFO_AW'(i_push.num);
            r_rd  <= r_rd + OFIFO_AW'(pop);
            r_cnt <= r_cnt + (OFIFO_AW + 1)'(i_push.num) - (OFIFO_AW + 1)'(pop);
        end
    end

endmodule

FILE: rtl/core/hpdq_core.sv
// Edge classifier, timers and event queue of the hot-plug-detect block.
// Registers one item, updates all state in one pass and pushes its results.
// Depends on hpdq_pkg for codes, t_cfg and t_push.
module hpdq_core #(
    parameter int QUEUE_SLOTS = hpdq_pkg::QUEUE_SLOTS_DEF,
    parameter int TIMER_BITS  = hpdq_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic                          i_level,
    input  hpdq_pkg::t_cfg                i_cfg,
    input  logic [hpdq_pkg::OFIFO_AW:0]   i_fifo_cnt,
    output hpdq_pkg::t_push               o_push
);
    import hpdq_pkg::*;

    localparam int QW   = $clog2(QUEUE_SLOTS);
    localparam int QCAP = QUEUE_SLOTS - 1;
    localparam int CW   = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int SW   = OFIFO_AW + 2;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;
    localparam logic [TIMER_BITS-1:0] TONE = TIMER_BITS'(1);

    function automatic logic [TIMER_BITS-1:0] f_load(input logic [CFG_W-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext > CW'(TMAX)) begin
            return TMAX;
        end
        return ext[TIMER_BITS-1:0];
    endfunction

    logic                   r_in_vld;
    logic                   r_in_cmd;
    logic                   r_in_lvl;
    logic [1:0]             r_q [QUEUE_SLOTS];
    logic [1:0]             n_q [QUEUE_SLOTS];
    logic [QW-1:0]          r_q_cnt, n_q_cnt;
    logic [1:0]             r_newest, n_newest;
    logic                   r_prev_lvl, n_prev_lvl;
    logic [TIMER_BITS-1:0]  r_since, n_since;
    logic [1:0]             r_reported, n_reported;
    logic [TIMER_BITS-1:0]  r_lvl_tmr, n_lvl_tmr;
    logic                   r_lvl_arm, n_lvl_arm;
    logic [TIMER_BITS-1:0]  r_gap_tmr, n_gap_tmr;
    logic                   r_gap_arm, n_gap_arm;
    logic                   e_emit, g_emit;
    logic [1:0]             e_code, g_code;
    logic [CW-1:0]          dlt;
    logic                   accept;
    t_push                  push;

    assign o_ready = i_rst_n &&
                     ((SW'(i_fifo_cnt) + (r_in_vld ? SW'(2) : SW'(0)) + SW'(2))
                      <= SW'(OFIFO_DEPTH));
    assign accept  = i_valid && o_ready;
    assign dlt     = CW'(r_since);
    assign o_push  = push;

    always_comb begin
        n_q        = r_q;
        n_q_cnt    = r_q_cnt;
        n_newest   = r_newest;
        n_prev_lvl = r_prev_lvl;
        n_since    = r_since;
        n_reported = r_reported;
        n_lvl_tmr  = r_lvl_tmr;
        n_lvl_arm  = r_lvl_arm;
        n_gap_tmr  = r_gap_tmr;
        n_gap_arm  = r_gap_arm;
        e_emit     = 1'b0;
        e_code     = EV_NONE;
        g_emit     = 1'b0;
        g_code     = EV_NONE;
        if (r_in_vld) begin
            if (!r_in_cmd) begin
                if (r_since != TMAX) begin
                    n_since = r_since + TONE;
                end
                if (r_lvl_arm) begin
                    if (r_lvl_tmr <= TONE) begin
                        n_lvl_arm = 1'b0;
                        n_lvl_tmr = '0;
                        if ((r_in_lvl ? EV_HIGH : EV_LOW) != r_reported) begin
                            e_emit     = 1'b1;
                            e_code     = r_in_lvl ? EV_HIGH : EV_LOW;
                            n_reported = e_code;
                        end
                    end else begin
                        n_lvl_tmr = r_lvl_tmr - TONE;
                    end
                end
                if (r_gap_arm) begin
                    if (r_gap_tmr <= TONE) begin
                        n_gap_tmr = '0;
                        g_emit    = 1'b1;
                        if (r_q_cnt != '0) begin
                            g_code = r_q[0];
                            for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
                                n_q[i] = r_q[i+1];
                            end
                            n_q_cnt = r_q_cnt - QW'(1);
                        end
                        n_reported = g_code;
                        if (r_q_cnt > QW'(1)) begin
                            n_gap_tmr = f_load(i_cfg.queue_gap);
                            n_gap_arm = 1'b1;
                        end else begin
                            n_gap_arm = 1'b0;
                        end
                    end else begin
                        n_gap_tmr = r_gap_tmr - TONE;
                    end
                end
            end else begin
                n_since   = '0;
                n_lvl_arm = 1'b0;
                if (r_prev_lvl != r_in_lvl) begin
                    n_prev_lvl = r_in_lvl;
                    if (r_in_lvl) begin
                        if (dlt <= CW'(i_cfg.glitch_limit)) begin
                            n_lvl_tmr = f_load(i_cfg.level_delay);
                            n_lvl_arm = 1'b1;
                        end else if (dlt <= CW'(i_cfg.irq_limit)) begin
                            if ((r_q_cnt != '0) || (r_reported == EV_LOW)) begin
                                n_newest = EV_IRQ;
                                if (QCAP == 1) begin
                                    n_q[0]  = EV_IRQ;
                                    n_q_cnt = QW'(1);
                                end else begin
                                    n_q[0]  = ((r_q_cnt != '0) && (r_newest != EV_LOW))
                                              ? r_newest : EV_HIGH;
                                    n_q[1]  = EV_IRQ;
                                    n_q_cnt = QW'(2);
                                end
                            end else begin
                                e_emit     = 1'b1;
                                e_code     = EV_IRQ;
                                n_reported = EV_IRQ;
                                n_gap_arm  = 1'b0;
                            end
                        end else begin
                            e_emit     = 1'b1;
                            e_code     = EV_LOW;
                            n_reported = EV_LOW;
                            n_q_cnt    = '0;
                            n_gap_arm  = 1'b0;
                            n_lvl_tmr  = f_load(i_cfg.level_delay);
                            n_lvl_arm  = 1'b1;
                        end
                    end else begin
                        if (dlt > CW'(i_cfg.irq_limit)) begin
                            if (r_q_cnt == '0) begin
                                e_emit     = 1'b1;
                                e_code     = EV_HIGH;
                                n_reported = EV_HIGH;
                                n_gap_arm  = 1'b0;
                            end else begin
                                n_newest = EV_HIGH;
                                if (r_q_cnt == QW'(QCAP)) begin
                                    for (int i = 0; i < QUEUE_SLOTS - 1; i++) begin
                                        n_q[i] = r_q[i+1];
                                    end
                                    n_q[QW'(QCAP - 1)] = EV_HIGH;
                                end else begin
                                    n_q[r_q_cnt] = EV_HIGH;
                                    n_q_cnt      = r_q_cnt + QW'(1);
                                end
                            end
                        end
                        n_lvl_tmr = f_load(i_cfg.level_delay);
                        n_lvl_arm = 1'b1;
                    end
                end
            end
        end
        push.num   = 2'(e_emit) + 2'(g_emit);
        push.code0 = e_emit ? e_code : g_code;
        push.code1 = g_code;
    end

    always_ff @(posedge i_clk) begin
        r_in_cmd <= i_cmd;
        r_in_lvl <= i_level;
        r_q      <= n_q;
        r_newest <= n_newest;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld   <= 1'b0;
            r_q_cnt    <= '0;
            r_prev_lvl <= 1'b0;
            r_since    <= '0;
            r_reported <= EV_NONE;
            r_lvl_tmr  <= '0;
            r_lvl_arm  <= 1'b0;
            r_gap_tmr  <= '0;
            r_gap_arm  <= 1'b0;
        end else begin
            r_in_vld   <= accept;
            r_q_cnt    <= n_q_cnt;
            r_prev_lvl <= n_prev_lvl;
            r_since    <= n_since;
            r_reported <= n_reported;
            r_lvl_tmr  <= n_lvl_tmr;
            r_lvl_arm  <= n_lvl_arm;
            r_gap_tmr  <= n_gap_tmr;
            r_gap_arm  <= n_gap_arm;
        end
    end

    a_queue_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_cnt <= QW'(QCAP))
        else $error("event queue holds more entries than its capacity");

    a_two_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.num == 2'd2) |-> (r_in_vld && !r_in_cmd))
        else $error("two results produced by something other than a tick");

    a_fifo_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |-> ((SW'(i_fifo_cnt) + SW'(push.num)) <= SW'(OFIFO_DEPTH)))
        else $error("result FIFO overflow");

    a_edge_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_in_cmd) |=> ((r_since == '0) && !r_lvl_arm ||
                                    (r_since == '0) && (r_lvl_tmr == f_load(i_cfg.level_delay))))
        else $error("edge did not restart the interval and level timers");

endmodule

FILE: rtl/core/hotplug_detect_event_queue.sv
// Top level of the hot-plug-detect event queue.
// Instantiates hpdq_cfg_regs, hpdq_core and hpdq_out_fifo; depends on hpdq_pkg.
//
// The slave stream carries one item per transfer: tuser bit 0 selects a time
// tick (0) or a pin edge report (1), and tdata bit 0 is the sampled pin level.
// The master stream sends one event per transfer: tdata bits 1:0 hold the
// event code (none, low, high, irq) and tlast marks the final event caused by
// one input item. An item produces zero, one or two events.
// The configuration channel writes one of four 24-bit registers (glitch
// limit, IRQ limit, level delay, queue gap) by index; it is ready out of reset.
// An accepted item is registered, processed in the next cycle and its events
// are written into the result FIFO, which presents them on the master side.
// One item can be taken every cycle; the rate is bounded by the eight-entry
// result FIFO, which drains one event per cycle while the receiver is ready.
// When the receiver stalls, the FIFO fills and tready drops once the FIFO
// could not hold two events for a new item and two for the one in process.
// Reset loads the register defaults, empties the queue and the FIFO and
// disarms both timers; it is synchronous, active low, and both ready
// outputs stay low while it is asserted.
module hotplug_detect_event_queue #(
    parameter int QUEUE_SLOTS = hpdq_pkg::QUEUE_SLOTS_DEF,
    parameter int TIMER_BITS  = hpdq_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // [0] pin_level
    input  logic [0:0]                    i_s_axis_tuser,   // [0] cmd
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [7:0]                    o_m_axis_tdata,   // [1:0] event_code
    output logic                          o_m_axis_tlast,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [hpdq_pkg::CFG_W-1:0]    i_cfg_data
);
    import hpdq_pkg::*;

    t_cfg               cfg;
    t_push              push;
    logic [OFIFO_AW:0]  fifo_cnt;
    logic [1:0]         out_code;

    hpdq_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    hpdq_core #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .TIMER_BITS  (TIMER_BITS)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_cmd      (i_s_axis_tuser[0]),
        .i_level    (i_s_axis_tdata[0]),
        .i_cfg      (cfg),
        .i_fifo_cnt (fifo_cnt),
        .o_push     (push)
    );

    hpdq_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (fifo_cnt),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_code  (out_code),
        .o_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {6'd0, out_code};

endmodule
